FILE: src/nvst_pkg.sv
`default_nettype none

package nvst_pkg;

    // field widths
    localparam int CHAN_W    = 4;
    localparam int KEY_W     = 7;
    localparam int VEL_W     = 7;
    localparam int CMD_W     = 2;
    localparam int NOTES_W   = 7;
    localparam int CHCNT_W   = 5;
    localparam int STARTED_W = 16;
    localparam int SLOTNUM_W = 6;
    localparam int FLAGIDX_W = 5;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    localparam int CHANNELS  = 16;
    localparam int DEF_SLOTS = 18;

    // event kinds carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONTROL  = 2'd2;

    localparam logic [KEY_W-1:0]     CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [STARTED_W-1:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [CHAN_W-1:0]    PERC_CHAN_RESET  = 4'd9;
    localparam logic [FLAGIDX_W-1:0] FLAG_END         = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_COUNT,
        ST_PEAK,
        ST_DONE
    } nvst_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ALLOC,
        OP_RELEASE,
        OP_ALL_OFF
    } nvst_op_t;

endpackage

`default_nettype wire

FILE: src/nvst_ram.sv
`default_nettype none

module nvst_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 18,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/note_voice_slot_tracker.sv
`default_nettype none

// Voice slot tracker: takes one decoded channel event per input beat (kind on
// s_tuser, channel/key/velocity on s_tdata) and returns one status beat per
// event. Each event walks the slot table once through a single read port of
// the slot memory, one slot per cycle; a note-on that is placed also walks
// the 16 channel-seen flags and updates the peaks. s_tready is high only
// between events; a finished status beat waits in its output register while
// the next event is taken. percussion_channel is written over the cfg
// channel, which is always ready, and should only change while no event is
// in flight.
module note_voice_slot_tracker #(
    parameter int SLOTS = nvst_pkg::DEF_SLOTS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // cfg_data: percussion_channel[3:0]
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nvst_pkg::CHAN_W-1:0]    cfg_data,
    // s_tuser: command[1:0]
    // s_tdata: channel[3:0], key_or_controller[10:4], velocity_or_value[17:11],
    //          zero[23:18]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [nvst_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [nvst_pkg::S_TUSER_W-1:0] s_tuser,
    // m_tdata: slot_taken[0], slot_number[6:1], note_dropped[7],
    //          slots_released[14:8], active_notes[21:15], peak_notes[28:22],
    //          peak_melodic[35:29], peak_percussion[42:36], peak_channels[47:43],
    //          channel_note_count[63:48]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [nvst_pkg::M_TDATA_W-1:0]      m_tdata
);

    import nvst_pkg::*;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCAN_W  = $clog2(SLOTS + 1);
    localparam int ENTRY_W = CHAN_W + KEY_W;

    // control state
    nvst_state_t state_reg, state_next;
    nvst_op_t    op_reg, op_next, op_dec;

    // event fields
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CHAN_W-1:0]  perc_chan_reg, perc_chan_next;

    // scan pipeline
    logic [SCAN_W-1:0]  scan_idx_reg, scan_idx_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [NOTES_W-1:0] released_reg, released_next;
    logic [NOTES_W-1:0] mel_reg, mel_next;
    logic [NOTES_W-1:0] perc_reg, perc_next;
    logic [CHANNELS-1:0] seen_reg, seen_next;
    logic [FLAGIDX_W-1:0] flag_idx_reg, flag_idx_next;
    logic [CHCNT_W-1:0] chans_reg, chans_next;

    // tracker state
    logic [SLOTS-1:0]   busy_reg, busy_next;
    logic [NOTES_W-1:0] busy_count_reg, busy_count_next;
    logic [NOTES_W-1:0] peak_total_reg, peak_total_next;
    logic [NOTES_W-1:0] peak_mel_reg, peak_mel_next;
    logic [NOTES_W-1:0] peak_perc_reg, peak_perc_next;
    logic [CHCNT_W-1:0] peak_chan_reg, peak_chan_next;
    logic [STARTED_W-1:0] started_reg [CHANNELS];
    logic [STARTED_W-1:0] started_next [CHANNELS];

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // slot memory port
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic [CHAN_W-1:0]  ent_chan;
    logic [KEY_W-1:0]   ent_key;
    logic               ent_busy;
    logic               scan_end;
    logic               out_free;

    // slot channel and key table
    nvst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_rd_addr = scan_idx_reg[IDX_W-1:0];
    assign ent_chan    = ram_rd_data[CHAN_W-1:0];
    assign ent_key     = ram_rd_data[ENTRY_W-1:CHAN_W];
    assign ent_busy    = busy_reg[proc_idx_reg];
    assign scan_end    = (scan_idx_reg == SCAN_W'(SLOTS)) && !proc_valid_reg;
    assign out_free    = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // event decoder
    always_comb begin
        unique case (s_tuser)
            CMD_NOTE_ON: begin
                op_dec = (s_tdata[17:11] != '0) ? OP_ALLOC : OP_RELEASE;
            end
            CMD_NOTE_OFF: begin
                op_dec = OP_RELEASE;
            end
            CMD_CONTROL: begin
                op_dec = (s_tdata[10:4] == CC_ALL_NOTES_OFF && s_tdata[17:11] == '0) ?
                         OP_ALL_OFF : OP_NONE;
            end
            default: begin
                op_dec = OP_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = (op_reg == OP_ALLOC && found_reg) ? ST_ALLOC : ST_DONE;
                end
            end
            ST_ALLOC: begin
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (flag_idx_reg == FLAG_END) begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next         = op_reg;
        chan_next       = chan_reg;
        key_next        = key_reg;
        perc_chan_next  = perc_chan_reg;
        scan_idx_next   = scan_idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        released_next   = released_reg;
        mel_next        = mel_reg;
        perc_next       = perc_reg;
        seen_next       = seen_reg;
        flag_idx_next   = flag_idx_reg;
        chans_next      = chans_reg;
        busy_next       = busy_reg;
        busy_count_next = busy_count_reg;
        peak_total_next = peak_total_reg;
        peak_mel_next   = peak_mel_reg;
        peak_perc_next  = peak_perc_reg;
        peak_chan_next  = peak_chan_reg;
        started_next    = started_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = hit_idx_reg;
        ram_wr_data     = {key_reg, chan_reg};

        // output beat leaves
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // percussion channel register
        if (cfg_valid) begin
            perc_chan_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = op_dec;
                    chan_next     = s_tdata[3:0];
                    key_next      = s_tdata[10:4];
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    hit_idx_next  = '0;
                    released_next = '0;
                    mel_next      = '0;
                    perc_next     = '0;
                    seen_next     = '0;
                end
            end
            ST_SCAN: begin
                // issue the next slot read
                if (scan_idx_reg != SCAN_W'(SLOTS)) begin
                    proc_valid_next = 1'b1;
                    proc_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next   = scan_idx_reg + SCAN_W'(1);
                end
                // look at the slot read last cycle
                if (proc_valid_reg) begin
                    if (ent_busy) begin
                        if (ent_chan == perc_chan_reg) begin
                            perc_next = perc_reg + NOTES_W'(1);
                        end else begin
                            mel_next = mel_reg + NOTES_W'(1);
                        end
                        seen_next[ent_chan] = 1'b1;
                    end
                    case (op_reg)
                        OP_ALLOC: begin
                            if (!ent_busy && !found_reg) begin
                                found_next   = 1'b1;
                                hit_idx_next = proc_idx_reg;
                            end
                        end
                        OP_RELEASE: begin
                            if (ent_busy && !found_reg && ent_chan == chan_reg &&
                                ent_key == key_reg) begin
                                found_next              = 1'b1;
                                hit_idx_next            = proc_idx_reg;
                                busy_next[proc_idx_reg] = 1'b0;
                                busy_count_next         = busy_count_reg - NOTES_W'(1);
                                released_next           = NOTES_W'(1);
                            end
                        end
                        OP_ALL_OFF: begin
                            if (ent_busy && ent_chan == chan_reg) begin
                                busy_next[proc_idx_reg] = 1'b0;
                                busy_count_next         = busy_count_reg - NOTES_W'(1);
                                released_next           = released_reg + NOTES_W'(1);
                                if (released_reg == '0) begin
                                    hit_idx_next = proc_idx_reg;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                // place the note and bump the counters
                ram_wr_en              = 1'b1;
                busy_next[hit_idx_reg] = 1'b1;
                busy_count_next        = busy_count_reg + NOTES_W'(1);
                if (started_reg[chan_reg] != COUNT_MAX) begin
                    started_next[chan_reg] = started_reg[chan_reg] + STARTED_W'(1);
                end
                if (chan_reg == perc_chan_reg) begin
                    perc_next = perc_reg + NOTES_W'(1);
                end else begin
                    mel_next = mel_reg + NOTES_W'(1);
                end
                seen_next[chan_reg] = 1'b1;
                flag_idx_next       = '0;
                chans_next          = '0;
            end
            ST_COUNT: begin
                // one channel flag per cycle
                if (flag_idx_reg != FLAG_END) begin
                    chans_next    = chans_reg + CHCNT_W'(seen_reg[flag_idx_reg[3:0]]);
                    flag_idx_next = flag_idx_reg + FLAGIDX_W'(1);
                end
            end
            ST_PEAK: begin
                if (busy_count_reg > peak_total_reg) begin
                    peak_total_next = busy_count_reg;
                end
                if (mel_reg > peak_mel_reg) begin
                    peak_mel_next = mel_reg;
                end
                if (perc_reg > peak_perc_reg) begin
                    peak_perc_next = perc_reg;
                end
                if (chans_reg > peak_chan_reg) begin
                    peak_chan_next = chans_reg;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        started_reg[chan_reg],
                        peak_chan_reg,
                        peak_perc_reg,
                        peak_mel_reg,
                        peak_total_reg,
                        busy_count_reg,
                        released_reg,
                        (op_reg == OP_ALLOC) && !found_reg,
                        SLOTNUM_W'(hit_idx_reg),
                        (op_reg == OP_ALLOC) && found_reg
                    };
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            perc_chan_reg  <= PERC_CHAN_RESET;
            proc_valid_reg <= 1'b0;
            busy_reg       <= '0;
            busy_count_reg <= '0;
            peak_total_reg <= '0;
            peak_mel_reg   <= '0;
            peak_perc_reg  <= '0;
            peak_chan_reg  <= '0;
            started_reg    <= '{default: '0};
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            perc_chan_reg  <= perc_chan_next;
            proc_valid_reg <= proc_valid_next;
            busy_reg       <= busy_next;
            busy_count_reg <= busy_count_next;
            peak_total_reg <= peak_total_next;
            peak_mel_reg   <= peak_mel_next;
            peak_perc_reg  <= peak_perc_next;
            peak_chan_reg  <= peak_chan_next;
            started_reg    <= started_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        chan_reg     <= chan_next;
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
        proc_idx_reg <= proc_idx_next;
        found_reg    <= found_next;
        hit_idx_reg  <= hit_idx_next;
        released_reg <= released_next;
        mel_reg      <= mel_next;
        perc_reg     <= perc_next;
        seen_reg     <= seen_next;
        flag_idx_reg <= flag_idx_next;
        chans_reg    <= chans_next;
        m_tdata_reg  <= m_tdata_next;
    end

`ifndef SYNTH
    // busy count follows the slot flags between events
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (busy_count_reg == NOTES_W'($countones(busy_reg))))
        else $error("busy count out of step with slot flags");

    // never more notes than slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_count_reg <= NOTES_W'(SLOTS))
        else $error("busy count above slot count");

    // peak total covers the current count between events
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (peak_total_reg >= busy_count_reg))
        else $error("peak total below active count");

    // a placed note and a dropped note never share a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[7]))
        else $error("status beat both placed and dropped");
`endif

endmodule

`default_nettype wire

FILE: dv/tb.sv
module tb;
    import nvst_pkg::*;

    localparam int SLOT_COUNT  = DEF_SLOTS;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 34;
    localparam int CALM_FROM   = 320;   // no idling on either side in this event range
    localparam int CALM_TO     = 440;
    localparam int HOLD_AT     = 120;   // receiver hold-off starts near this event
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;     // idle cycles before a register write or the end of a drain
    localparam int TAIL_CYCLES = 2 * (SLOT_COUNT + 23);
    localparam int STALL_LIMIT = 4000;

    typedef enum logic [1:0] {
        ENTRY_EVENT,
        ENTRY_CFG,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct {
        entry_kind_t        kind;
        logic [CMD_W-1:0]   command;
        logic [CHAN_W-1:0]  channel;
        logic [KEY_W-1:0]   key;
        logic [VEL_W-1:0]   vel;
        logic [CHAN_W-1:0]  cfg_value;
    } plan_entry_t;

    // status beat, last field in the lowest bits
    typedef struct packed {
        logic [STARTED_W-1:0] channel_note_count;
        logic [CHCNT_W-1:0]   peak_channels;
        logic [NOTES_W-1:0]   peak_percussion;
        logic [NOTES_W-1:0]   peak_melodic;
        logic [NOTES_W-1:0]   peak_notes;
        logic [NOTES_W-1:0]   active_notes;
        logic [NOTES_W-1:0]   slots_released;
        logic                 note_dropped;
        logic [SLOTNUM_W-1:0] slot_number;
        logic                 slot_taken;
    } voice_status_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CHAN_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    plan_entry_t   event_plan[$];
    voice_status_t expected_status[$];
    logic [10:0]   sounding[$];     // {channel, key} of notes the plan believes are held

    // shadow of the slot table
    logic                 slot_used  [SLOT_COUNT] = '{default: 1'b0};
    logic [CHAN_W-1:0]    slot_chan  [SLOT_COUNT];
    logic [KEY_W-1:0]     slot_note  [SLOT_COUNT];
    logic [STARTED_W-1:0] notes_started [CHANNELS] = '{default: '0};
    logic [NOTES_W-1:0]   notes_held = '0;
    logic [NOTES_W-1:0]   peak_all   = '0;
    logic [NOTES_W-1:0]   peak_mel   = '0;
    logic [NOTES_W-1:0]   peak_drum  = '0;
    logic [CHCNT_W-1:0]   peak_chans = '0;
    logic [CHAN_W-1:0]    drum_chan  = PERC_CHAN_RESET;

    int  events_sent = 0;
    int  mismatches  = 0;
    int  settle      = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    int  idle_cycles = 0;
    wire calm = (events_sent >= CALM_FROM) && (events_sent < CALM_TO);

    note_voice_slot_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one event to the slot shadow and return the status it should report
    function automatic voice_status_t track_event(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                                  logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel);
        voice_status_t r;
        int            i;
        int            slot;
        int            mel;
        int            drum;
        bit [15:0]     seen;
        r = '0;
        if (cmd == CMD_NOTE_ON && vel != 0) begin
            slot = -1;
            for (i = SLOT_COUNT - 1; i >= 0; i--)
                if (!slot_used[i])
                    slot = i;
            if (slot >= 0) begin
                slot_used[slot] = 1'b1;
                slot_chan[slot] = ch;
                slot_note[slot] = key;
                notes_held = notes_held + 7'd1;
                if (notes_started[ch] != COUNT_MAX)
                    notes_started[ch] = notes_started[ch] + 16'd1;
                // peaks are only raised at an allocation
                mel  = 0;
                drum = 0;
                seen = '0;
                for (i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_used[i]) begin
                        if (slot_chan[i] == drum_chan)
                            drum++;
                        else
                            mel++;
                        seen[slot_chan[i]] = 1'b1;
                    end
                end
                if (notes_held > peak_all)
                    peak_all = notes_held;
                if (mel > peak_mel)
                    peak_mel = 7'(mel);
                if (drum > peak_drum)
                    peak_drum = 7'(drum);
                if ($countones(seen) > peak_chans)
                    peak_chans = 5'($countones(seen));
                r.slot_taken  = 1'b1;
                r.slot_number = 6'(slot);
            end else begin
                r.note_dropped = 1'b1;
            end
        end else if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON) begin
            // lowest slot holding this channel and key
            slot = -1;
            for (i = SLOT_COUNT - 1; i >= 0; i--)
                if (slot_used[i] && slot_chan[i] == ch && slot_note[i] == key)
                    slot = i;
            if (slot >= 0) begin
                slot_used[slot]  = 1'b0;
                notes_held       = notes_held - 7'd1;
                r.slots_released = 7'd1;
                r.slot_number    = 6'(slot);
            end
        end else if (cmd == CMD_CONTROL && key == CC_ALL_NOTES_OFF && vel == 0) begin
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (slot_used[i] && slot_chan[i] == ch) begin
                    slot_used[i] = 1'b0;
                    notes_held   = notes_held - 7'd1;
                    if (r.slots_released == 0)
                        r.slot_number = 6'(i);
                    r.slots_released = r.slots_released + 7'd1;
                end
            end
        end
        r.active_notes       = notes_held;
        r.peak_notes         = peak_all;
        r.peak_melodic       = peak_mel;
        r.peak_percussion    = peak_drum;
        r.peak_channels      = peak_chans;
        r.channel_note_count = notes_started[ch];
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // queue one event and keep the list of held notes roughly in step
    task automatic add_event(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                             logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel);
        plan_entry_t e;
        int          j;
        e = '{kind: ENTRY_EVENT, command: cmd, channel: ch, key: key, vel: vel, cfg_value: '0};
        event_plan.push_back(e);
        if (cmd == CMD_NOTE_ON && vel != 0) begin
            if (sounding.size() < SLOT_COUNT)
                sounding.push_back({ch, key});
        end else if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON) begin
            for (j = 0; j < sounding.size(); j++) begin
                if (sounding[j] == {ch, key}) begin
                    sounding.delete(j);
                    break;
                end
            end
        end else if (cmd == CMD_CONTROL && key == CC_ALL_NOTES_OFF && vel == 0) begin
            for (j = sounding.size() - 1; j >= 0; j--)
                if (sounding[j][10:7] == ch)
                    sounding.delete(j);
        end
    endtask

    task automatic add_marker(entry_kind_t kind, logic [CHAN_W-1:0] value);
        plan_entry_t e;
        e = '{kind: kind, command: '0, channel: '0, key: '0, vel: '0, cfg_value: value};
        event_plan.push_back(e);
    endtask

    // mostly well-formed play: note-ons and releases of held notes, in fill and
    // drain moods, with some all-notes-off and a share of noise
    task automatic add_random_phase(int count);
        int          n;
        int          r;
        int          pick;
        int          on_pct;
        logic [10:0] held;
        on_pct = 75;
        for (n = 0; n < count; n++) begin
            if (n % 30 == 0)
                on_pct = $urandom_range(1) ? 75 : 30;
            r = $urandom_range(99);
            if (r < 87 && (r < on_pct * 87 / 100 || sounding.size() == 0)) begin
                add_event(CMD_NOTE_ON, 4'($urandom_range(15)), 7'($urandom_range(127)),
                          7'($urandom_range(127, 1)));
            end else if (r < 87) begin
                pick = $urandom_range(sounding.size() - 1);
                held = sounding[pick];
                if ($urandom_range(3) == 0)
                    add_event(CMD_NOTE_ON, held[10:7], held[6:0], '0);
                else
                    add_event(CMD_NOTE_OFF, held[10:7], held[6:0], 7'($urandom_range(127)));
            end else if (r < 90) begin
                if (sounding.size() != 0)
                    held = sounding[$urandom_range(sounding.size() - 1)];
                else
                    held = 11'($urandom_range(2047));
                add_event(CMD_CONTROL, held[10:7], CC_ALL_NOTES_OFF, '0);
            end else begin
                case ($urandom_range(3))
                    0: add_event(CMD_NOTE_OFF, 4'($urandom_range(15)), 7'($urandom_range(127)),
                                 7'($urandom_range(127)));
                    1: add_event(CMD_CONTROL, 4'($urandom_range(15)),
                                 $urandom_range(1) ? CC_ALL_NOTES_OFF : 7'($urandom_range(127)),
                                 7'($urandom_range(127, 1)));
                    2: add_event(CMD_UNUSED, 4'($urandom_range(15)), 7'($urandom_range(127)),
                                 7'($urandom_range(127)));
                    default: add_event(CMD_NOTE_ON, 4'($urandom_range(15)),
                                       7'($urandom_range(127)), '0);
                endcase
            end
        end
    endtask

    // plan, reset and end of run
    initial begin
        int i;
        // fill every slot over all channels, two extra notes on the drum channel
        for (i = 0; i < SLOT_COUNT; i++)
            add_event(CMD_NOTE_ON, (i < CHANNELS) ? 4'(i) : PERC_CHAN_RESET,
                      (i == 15) ? 7'd127 : 7'(i * 8), (i == 0) ? 7'd127 : 7'(i * 7 + 1));
        // table full: dropped
        add_event(CMD_NOTE_ON, 4'd3, 7'd5, 7'd1);
        // note-off with velocity and note-on with zero velocity on held notes, then a note-off with no match
        add_event(CMD_NOTE_OFF, 4'd15, 7'd127, 7'd127);
        add_event(CMD_NOTE_ON, 4'd0, 7'd0, 7'd0);
        add_event(CMD_NOTE_OFF, 4'd2, 7'd99, 7'd0);
        // ignored controls and unused command
        add_event(CMD_CONTROL, PERC_CHAN_RESET, CC_ALL_NOTES_OFF, 7'd127);
        add_event(CMD_CONTROL, PERC_CHAN_RESET, 7'd0, 7'd0);
        add_event(CMD_UNUSED, 4'd15, 7'd127, 7'd127);
        // all notes off on a channel with three held notes
        add_event(CMD_CONTROL, PERC_CHAN_RESET, CC_ALL_NOTES_OFF, 7'd0);

        add_marker(ENTRY_CFG, 4'd0);
        add_random_phase(220);
        add_marker(ENTRY_CFG, 4'd15);
        add_random_phase(110);
        add_marker(ENTRY_DRAIN, '0);
        add_random_phase(110);
        add_marker(ENTRY_CFG, 4'($urandom_range(14, 1)));
        add_random_phase(220);
        add_marker(ENTRY_CFG, PERC_CHAN_RESET);
        add_random_phase(110);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (event_plan.size() != 0 || s_tvalid || cfg_valid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_status.size() == 0 && event_plan.size() == 0)
            $display("[note_voice_slot_tracker] OK");
        else
            $display("[note_voice_slot_tracker] ERROR");
        $finish;
    end

    // event and register driver
    always @(posedge aclk) begin
        bit next_valid;
        bit next_cfg;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            next_valid = s_tvalid && !s_tready;
            next_cfg   = cfg_valid && !cfg_ready;
            // predict at the input beat
            if (s_tvalid && s_tready) begin
                expected_status.push_back(track_event(s_tuser, s_tdata[3:0], s_tdata[10:4],
                                                      s_tdata[17:11]));
                events_sent++;
            end
            if (cfg_valid && cfg_ready)
                drum_chan = cfg_data;
            if (!next_valid && !next_cfg && event_plan.size() != 0) begin
                if (event_plan[0].kind == ENTRY_EVENT) begin
                    if (calm || $urandom_range(99) >= IDLE_PCT) begin
                        s_tdata    <= {6'b0, event_plan[0].vel, event_plan[0].key,
                                       event_plan[0].channel};
                        s_tuser    <= event_plan[0].command;
                        next_valid = 1'b1;
                        void'(event_plan.pop_front());
                    end
                end else if (expected_status.size() != 0) begin
                    settle = 0;
                end else if (settle < SETTLE) begin
                    settle++;
                end else begin
                    // block is drained: write the register or just resume
                    settle = 0;
                    if (event_plan[0].kind == ENTRY_CFG) begin
                        cfg_data <= event_plan[0].cfg_value;
                        next_cfg = 1'b1;
                    end
                    void'(event_plan.pop_front());
                end
            end
            s_tvalid  <= next_valid;
            cfg_valid <= next_cfg;
        end
    end

    // status monitor and receiver stalls
    always @(posedge aclk) begin
        voice_status_t got;
        voice_status_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_status.size() == 0) begin
                    $error("status beat with no event pending: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("slot_taken", want.slot_taken, got.slot_taken);
                    check_field("slot_number", want.slot_number, got.slot_number);
                    check_field("note_dropped", want.note_dropped, got.note_dropped);
                    check_field("slots_released", want.slots_released, got.slots_released);
                    check_field("active_notes", want.active_notes, got.active_notes);
                    check_field("peak_notes", want.peak_notes, got.peak_notes);
                    check_field("peak_melodic", want.peak_melodic, got.peak_melodic);
                    check_field("peak_percussion", want.peak_percussion, got.peak_percussion);
                    check_field("peak_channels", want.peak_channels, got.peak_channels);
                    check_field("channel_note_count", want.channel_note_count,
                                got.channel_note_count);
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && events_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("[note_voice_slot_tracker] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: sim.f
src/nvst_pkg.sv
src/nvst_ram.sv
src/note_voice_slot_tracker.sv
dv/tb.sv
